/* sv/srld_pkg.sv */
// Shared types, field widths, defaults and command codes for the scroll region block.
package srld_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_ROWS_DEF  = 64;
    localparam int MAX_COLS_DEF  = 256;
    localparam int CELL_BITS_DEF = 32;

    // Field widths of the request and result
    localparam int MODE_W   = 2;
    localparam int COUNT_W  = 7;
    localparam int TOP_W    = 6;
    localparam int BOTTOM_W = 7;
    localparam int FILL_W   = 32;
    localparam int RROW_W   = 6;
    localparam int RCOL_W   = 8;
    localparam int VALUE_W  = 32;

    // Configuration registers
    localparam int COLS_CFG_W = 9;
    localparam int ROWS_CFG_W = 7;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'd1;

    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 9'd80;
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 7'd24;

    // Command codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [COUNT_W-1:0]  line_count;
        logic [TOP_W-1:0]    region_top;
        logic [BOTTOM_W-1:0] region_bottom;
        logic [FILL_W-1:0]   fill_cell;
        logic [RROW_W-1:0]   read_row;
        logic [RCOL_W-1:0]   read_col;
    } t_in_req;

    typedef struct packed {
        logic [VALUE_W-1:0] cell_value;
        logic               status;
    } t_out_res;

    // Row map operation issued by the sequencer
    typedef struct packed {
        logic shift;
        logic up;
    } t_map_op;

endpackage

/* sv/scroll_region_line_insert_delete.sv */
// Top level: command sequencer for scroll region line insert, delete and cell read.
// Insert/delete: for each of n lines (line count capped at the region height) the row map rotation walk
//   over the region height and the row fill sweep over the effective column count run together.
// Read: row map lookup, then registered cell memory read; bad commands go straight to the result;
//   one request at a time, the next is taken once the result is registered.
// Reset: synchronous, active low; a row map identity pass and a clearing pass of the cell memory over
//   all MAX_ROWS * MAX_COLS cells run together while no request is taken.
module scroll_region_line_insert_delete #(
    parameter int MAX_ROWS  = srld_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS  = srld_pkg::MAX_COLS_DEF,
    parameter int CELL_BITS = srld_pkg::CELL_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  srld_pkg::t_in_req                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output srld_pkg::t_out_res                  o_out_data,
    input  logic                                i_cfg_we,
    input  logic [srld_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [srld_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int NC_W  = $clog2(MAX_COLS + 1);
    localparam int NR_W  = $clog2(MAX_ROWS + 1);
    localparam int ECW   = (NC_W > srld_pkg::COLS_CFG_W) ? NC_W : srld_pkg::COLS_CFG_W;
    localparam int ERW   = (NR_W > srld_pkg::BOTTOM_W) ? NR_W : srld_pkg::BOTTOM_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_LOOK, S_ROT, S_FILL,
        S_RMAP, S_RCELL, S_RWAIT, S_DONE
    } t_state;

    t_state                                r_state;
    srld_pkg::t_in_req                     r_req;
    logic [srld_pkg::COLS_CFG_W-1:0]       r_cols;
    logic [srld_pkg::ROWS_CFG_W-1:0]       r_rows;
    logic [srld_pkg::COUNT_W-1:0]          r_left;
    logic [srld_pkg::VALUE_W-1:0]          r_value;
    logic                                  r_status;
    logic                                  r_out_valid;
    srld_pkg::t_out_res                    r_out;

    logic [ERW-1:0]                        rows_ext;
    logic [ERW-1:0]                        eff_rows;
    logic [ECW-1:0]                        cols_ext;
    logic [ECW-1:0]                        eff_cols;
    logic [ECW-1:0]                        cols_m1;
    logic [ERW-1:0]                        top_ext;
    logic [ERW-1:0]                        bottom_ext;
    logic [ERW-1:0]                        last_ext;
    logic [ERW-1:0]                        rrow_ext;
    logic [ECW-1:0]                        rcol_ext;
    logic [srld_pkg::COUNT_W-1:0]          height;
    logic [srld_pkg::COUNT_W-1:0]          count_sat;
    logic                                  region_bad;
    logic                                  read_bad;
    logic                                  is_rot;
    logic [ROW_W-1:0]                      top_row;
    logic [ROW_W-1:0]                      last_row;
    logic [ROW_W-1:0]                      map_rd_addr;
    logic [ROW_W-1:0]                      map_rd_data;
    logic                                  map_busy;
    logic [CELL_BITS-1:0]                  cell_rd_data;
    logic [63:0]                           cell_wide;
    logic                                  cell_busy;
    logic                                  fill_start;
    srld_pkg::t_map_op                     map_op;

    // Effective screen size and range checks on the held request
    always_comb begin
        rows_ext   = ERW'(r_rows);
        eff_rows   = (rows_ext > ERW'(MAX_ROWS)) ? ERW'(MAX_ROWS) : rows_ext;
        cols_ext   = ECW'(r_cols);
        eff_cols   = (cols_ext > ECW'(MAX_COLS)) ? ECW'(MAX_COLS) : cols_ext;
        cols_m1    = eff_cols - 1'b1;
        top_ext    = ERW'(r_req.region_top);
        bottom_ext = ERW'(r_req.region_bottom);
        last_ext   = bottom_ext - 1'b1;
        rrow_ext   = ERW'(r_req.read_row);
        rcol_ext   = ECW'(r_req.read_col);
        height     = r_req.region_bottom - srld_pkg::COUNT_W'(r_req.region_top);
        count_sat  = (r_req.line_count > height) ? height : r_req.line_count;
        region_bad = (bottom_ext > eff_rows) || (top_ext >= bottom_ext);
        read_bad   = (rrow_ext >= eff_rows) || (rcol_ext >= eff_cols);
        is_rot     = (r_req.mode == srld_pkg::MODE_INSERT)
                  || (r_req.mode == srld_pkg::MODE_DELETE);
        top_row    = top_ext[ROW_W-1:0];
        last_row   = last_ext[ROW_W-1:0];
    end

    // Row map port: the lookup row, or the row leaving the region
    assign map_rd_addr = (r_state == S_RMAP) ? rrow_ext[ROW_W-1:0] :
                         (r_req.mode == srld_pkg::MODE_INSERT) ? last_row : top_row;

    assign fill_start   = (r_state == S_ROT) && (eff_cols != '0);
    assign map_op.shift = (r_state == S_ROT);
    assign map_op.up    = (r_req.mode == srld_pkg::MODE_DELETE);
    assign cell_wide    = 64'(cell_rd_data);

    srld_rowmap #(
        .MAX_ROWS (MAX_ROWS),
        .ROW_W    (ROW_W)
    ) u_rowmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (map_op),
        .i_top     (top_row),
        .i_last    (last_row),
        .i_moved   (map_rd_data),
        .i_rd_addr (map_rd_addr),
        .o_rd_data (map_rd_data),
        .o_busy    (map_busy)
    );

    srld_cells #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .CELL_BITS (CELL_BITS),
        .ROW_W     (ROW_W),
        .COL_W     (COL_W)
    ) u_cells (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fill      (fill_start),
        .i_fill_row  (map_rd_data),
        .i_fill_last (cols_m1[COL_W-1:0]),
        .i_fill_cell (CELL_BITS'(r_req.fill_cell)),
        .i_rd_row    (map_rd_data),
        .i_rd_col    (rcol_ext[COL_W-1:0]),
        .o_rd_data   (cell_rd_data),
        .o_busy      (cell_busy)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= srld_pkg::COLS_RESET;
            r_rows <= srld_pkg::ROWS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                srld_pkg::CFG_COLUMNS: r_cols <= i_cfg_data;
                srld_pkg::CFG_ROWS:    r_rows <= i_cfg_data[srld_pkg::ROWS_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Latch the request as it is taken
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_req <= i_in_data;
        end
    end

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
            r_left      <= '0;
            r_status    <= 1'b0;
            r_value     <= '0;
        end else begin
            // Drop a taken result unless a new one replaces it
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (!cell_busy && !map_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_value <= '0;
                    r_left  <= count_sat;
                    if (is_rot) begin
                        r_status <= region_bad;
                        if (region_bad || (count_sat == '0)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_LOOK;
                        end
                    end else if ((r_req.mode == srld_pkg::MODE_READ) && !read_bad) begin
                        r_status <= 1'b0;
                        r_state  <= S_RMAP;
                    end else begin
                        r_status <= 1'b1;
                        r_state  <= S_DONE;
                    end
                end
                S_LOOK: begin
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    r_left  <= r_left - 1'b1;
                    r_state <= S_FILL;
                end
                S_FILL: begin
                    if (!cell_busy && !map_busy) begin
                        r_state <= (r_left == '0) ? S_DONE : S_LOOK;
                    end
                end
                S_RMAP: begin
                    r_state <= S_RCELL;
                end
                S_RCELL: begin
                    r_state <= S_RWAIT;
                end
                S_RWAIT: begin
                    r_value <= cell_wide[srld_pkg::VALUE_W-1:0];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid      <= 1'b1;
                        r_out.cell_value <= r_value;
                        r_out.status     <= r_status;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // No request is taken while the cell memory is still sweeping
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> !cell_busy)
        else $error("request taken while cell memory busy");

    // A row fill is only requested with the sweep unit free
    a_fill_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill_start |-> !cell_busy)
        else $error("fill requested while sweep busy");

    // A rejected command never carries a cell value
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status) |-> (o_out_data.cell_value == '0))
        else $error("status set with non-zero cell value");

    // The line counter steps once per rotation
    a_left_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT) |=> (r_left == $past(r_left) - 1'b1))
        else $error("line counter did not step");
`endif

endmodule

/* sv/srld_rowmap.sv */
// Row indirection table: logical to physical row, rotated one entry per cycle.
module srld_rowmap #(
    parameter int MAX_ROWS = srld_pkg::MAX_ROWS_DEF,
    parameter int ROW_W    = $clog2(MAX_ROWS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  srld_pkg::t_map_op   i_op,
    input  logic [ROW_W-1:0]    i_top,
    input  logic [ROW_W-1:0]    i_last,
    input  logic [ROW_W-1:0]    i_moved,
    input  logic [ROW_W-1:0]    i_rd_addr,
    output logic [ROW_W-1:0]    o_rd_data,
    output logic                o_busy
);

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);

    logic [ROW_W-1:0] r_map [MAX_ROWS];
    logic [ROW_W-1:0] r_rd_data;
    logic [ROW_W-1:0] r_moved;
    logic [ROW_W-1:0] r_ptr;
    logic             r_busy;
    logic             r_init;
    logic             r_up;
    logic [ROW_W-1:0] ptr_first;
    logic [ROW_W-1:0] ptr_end;
    logic [ROW_W-1:0] wr_data;
    logic [ROW_W-1:0] rd_addr;

    // Walk the region: the first entry takes the moved row, each later one its old neighbour
    always_comb begin
        ptr_first = r_up ? i_last : i_top;
        ptr_end   = r_init ? ROW_LAST : (r_up ? i_top : i_last);
        wr_data   = r_init ? r_ptr : ((r_ptr == ptr_first) ? r_moved : r_rd_data);
        rd_addr   = r_busy ? r_ptr : i_rd_addr;
    end

    // Step the walk pointer; after reset write the identity table first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_init <= 1'b1;
            r_up   <= 1'b0;
            r_ptr  <= '0;
        end else if (r_busy) begin
            if (r_ptr == ptr_end) begin
                r_busy <= 1'b0;
                r_init <= 1'b0;
            end else if (r_up && !r_init) begin
                r_ptr <= r_ptr - 1'b1;
            end else begin
                r_ptr <= r_ptr + 1'b1;
            end
        end else if (i_op.shift) begin
            r_busy <= 1'b1;
            r_up   <= i_op.up;
            r_ptr  <= i_op.up ? i_last : i_top;
        end
    end

    // Hold the row that wraps round for the first write of the walk
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_op.shift) begin
            r_moved <= i_moved;
        end
    end

    // One write and one registered read per cycle, the write only while the walk runs
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_map[r_ptr] <= wr_data;
        end
        r_rd_data <= r_map[rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

/* sv/srld_cells.sv */
// Cell memory with its column sweep unit for row fills and the clearing pass.
module srld_cells #(
    parameter int MAX_ROWS  = srld_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS  = srld_pkg::MAX_COLS_DEF,
    parameter int CELL_BITS = srld_pkg::CELL_BITS_DEF,
    parameter int ROW_W     = $clog2(MAX_ROWS),
    parameter int COL_W     = $clog2(MAX_COLS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fill,
    input  logic [ROW_W-1:0]     i_fill_row,
    input  logic [COL_W-1:0]     i_fill_last,
    input  logic [CELL_BITS-1:0] i_fill_cell,
    input  logic [ROW_W-1:0]     i_rd_row,
    input  logic [COL_W-1:0]     i_rd_col,
    output logic [CELL_BITS-1:0] o_rd_data,
    output logic                 o_busy
);

    localparam int DEPTH = MAX_ROWS * (1 << COL_W);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLS - 1);

    logic [CELL_BITS-1:0] r_mem [DEPTH];
    logic [CELL_BITS-1:0] r_rd_data;
    logic [CELL_BITS-1:0] r_cell;
    logic                 r_busy;
    logic                 r_clear;
    logic [ROW_W-1:0]     r_row;
    logic [COL_W-1:0]     r_col;
    logic [COL_W-1:0]     r_last;
    logic                 row_end;

    assign row_end = (r_col == r_last);

    // Sweep columns; the clearing pass also steps through every row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_clear <= 1'b1;
            r_row   <= '0;
            r_col   <= '0;
            r_last  <= COL_LAST;
        end else if (r_busy) begin
            if (row_end) begin
                r_col <= '0;
                if (r_clear && (r_row != ROW_LAST)) begin
                    r_row <= r_row + 1'b1;
                end else begin
                    r_busy  <= 1'b0;
                    r_clear <= 1'b0;
                end
            end else begin
                r_col <= r_col + 1'b1;
            end
        end else if (i_fill) begin
            r_busy <= 1'b1;
            r_row  <= i_fill_row;
            r_col  <= '0;
            r_last <= i_fill_last;
        end
    end

    // Latch the fill value with the request
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_fill) begin
            r_cell <= i_fill_cell;
        end
    end

    // Write one cell per cycle while sweeping; the registered read runs every cycle
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[{r_row, r_col}] <= r_clear ? '0 : r_cell;
        end
        r_rd_data <= r_mem[{i_rd_row, i_rd_col}];
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Testbench for the scroll region line insert/delete block: directed table, then random phases.
module testbench;

    localparam int ROW_LIMIT       = srld_pkg::MAX_ROWS_DEF;
    localparam int COL_LIMIT       = srld_pkg::MAX_COLS_DEF;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 40;
    // Watchdog limit lies well above the clearing pass and the longest insert
    localparam int WATCHDOG_LIMIT  = 100000;
    localparam int PHASES          = 10;

    localparam logic [srld_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_BAD  = 1'b1;
    localparam logic KEYED       = 1'b1;
    localparam logic PREDICTED   = 1'b0;

    localparam srld_pkg::t_out_res ZERO_DONE = '{cell_value: '0, status: STATUS_DONE};
    localparam srld_pkg::t_out_res REJECTED  = '{cell_value: '0, status: STATUS_BAD};

    typedef struct packed {
        srld_pkg::t_in_req  req;
        logic               keyed;
        srld_pkg::t_out_res want;
    } t_script_row;

    typedef struct packed {
        logic [srld_pkg::CFG_DATA_W-1:0] cols_word;
        logic [srld_pkg::CFG_DATA_W-1:0] rows_word;
        logic [15:0]                     items;
    } t_geometry;

    // Screen sizes walked by the random part: extremes, capped and zero settings
    t_geometry geometry_plan [PHASES] = '{
        '{9'd8,   9'd24,  16'd140},
        '{9'd1,   9'd64,  16'd110},
        '{9'd0,   9'd12,  16'd60},
        '{9'd256, 9'd64,  16'd12},
        '{9'h1FF, 9'h1FF, 16'd12},
        '{9'd5,   9'd0,   16'd40},
        '{9'd3,   9'd2,   16'd80},
        '{9'd16,  9'd40,  16'd150},
        '{9'd12,  9'd65,  16'd120},
        '{9'd2,   9'd7,   16'd100}
    };

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    srld_pkg::t_in_req               in_data;
    logic                            out_valid;
    logic                            out_stall;
    srld_pkg::t_out_res              out_data;
    logic                            cfg_we;
    logic [srld_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [srld_pkg::CFG_DATA_W-1:0] cfg_data;

    // Shadow of the screen: row map, cells and geometry registers
    logic [srld_pkg::TOP_W-1:0]      row_map_m [ROW_LIMIT];
    logic [srld_pkg::VALUE_W-1:0]    screen_m  [ROW_LIMIT*COL_LIMIT];
    logic [srld_pkg::COLS_CFG_W-1:0] cols_m;
    logic [srld_pkg::ROWS_CFG_W-1:0] rows_m;

    srld_pkg::t_out_res awaited_results [$];
    t_script_row        script [$];
    int                 mismatches;
    int                 results_taken;
    int unsigned        idle_cycles;
    bit                 quiet_tx;
    bit                 quiet_rx;
    bit                 hold_off_req;

    scroll_region_line_insert_delete dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int usable_rows();
        return (rows_m > ROW_LIMIT) ? ROW_LIMIT : int'(rows_m);
    endfunction

    function automatic int usable_cols();
        return (cols_m > COL_LIMIT) ? COL_LIMIT : int'(cols_m);
    endfunction

    // Apply one request to the shadow screen and return the result it yields
    function automatic srld_pkg::t_out_res screen_command(input srld_pkg::t_in_req req);
        srld_pkg::t_out_res         res;
        int                         rows_now;
        int                         cols_now;
        int                         top;
        int                         bottom;
        int                         count;
        int                         phys;
        logic [srld_pkg::TOP_W-1:0] moved;
        rows_now = usable_rows();
        cols_now = usable_cols();
        top      = int'(req.region_top);
        bottom   = int'(req.region_bottom);
        count    = int'(req.line_count);
        res      = ZERO_DONE;
        case (req.mode)
            srld_pkg::MODE_INSERT, srld_pkg::MODE_DELETE: begin
                if (bottom > rows_now || top >= bottom) begin
                    res.status = STATUS_BAD;
                end else begin
                    if (count > bottom - top)
                        count = bottom - top;
                    repeat (count) begin
                        if (req.mode == srld_pkg::MODE_INSERT) begin
                            moved = row_map_m[bottom-1];
                            for (int r = bottom - 1; r > top; r--)
                                row_map_m[r] = row_map_m[r-1];
                            row_map_m[top] = moved;
                        end else begin
                            moved = row_map_m[top];
                            for (int r = top; r + 1 < bottom; r++)
                                row_map_m[r] = row_map_m[r+1];
                            row_map_m[bottom-1] = moved;
                        end
                        // Blank the row that wrapped round, up to the width in use
                        phys = int'(moved);
                        for (int c = 0; c < cols_now; c++)
                            screen_m[phys*COL_LIMIT + c] = req.fill_cell;
                    end
                end
            end
            srld_pkg::MODE_READ: begin
                if (req.read_row >= rows_now || req.read_col >= cols_now) begin
                    res.status = STATUS_BAD;
                end else begin
                    phys = int'(row_map_m[req.read_row]);
                    res.cell_value = screen_m[phys*COL_LIMIT + req.read_col];
                end
            end
            default: res.status = STATUS_BAD;
        endcase
        return res;
    endfunction

    function automatic srld_pkg::t_in_req cmd(input logic [srld_pkg::MODE_W-1:0] mode,
                                              input int count, input int top,
                                              input int bottom,
                                              input logic [srld_pkg::FILL_W-1:0] fill,
                                              input int rrow, input int rcol);
        srld_pkg::t_in_req req;
        req.mode          = mode;
        req.line_count    = count[srld_pkg::COUNT_W-1:0];
        req.region_top    = top[srld_pkg::TOP_W-1:0];
        req.region_bottom = bottom[srld_pkg::BOTTOM_W-1:0];
        req.fill_cell     = fill;
        req.read_row      = rrow[srld_pkg::RROW_W-1:0];
        req.read_col      = rcol[srld_pkg::RCOL_W-1:0];
        return req;
    endfunction

    // Offer one request after a random gap, hold it until taken, log its result
    task automatic issue_command(input srld_pkg::t_in_req req, input logic keyed,
                                 input srld_pkg::t_out_res want);
        int                 gap;
        srld_pkg::t_out_res predicted;
        gap = quiet_tx ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        predicted = screen_command(req);
        awaited_results.push_back(keyed ? want : predicted);
        @(negedge clk);
    endtask

    // Drop the request line and wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (awaited_results.size() != 0);
    endtask

    // Write both geometry registers while the block is idle
    task automatic set_geometry(input logic [srld_pkg::CFG_DATA_W-1:0] cols_word,
                                input logic [srld_pkg::CFG_DATA_W-1:0] rows_word);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_idx  <= srld_pkg::CFG_COLUMNS;
        cfg_data <= cols_word;
        @(negedge clk);
        cfg_idx  <= srld_pkg::CFG_ROWS;
        cfg_data <= rows_word;
        @(negedge clk);
        cfg_we   <= 1'b0;
        cols_m = cols_word[srld_pkg::COLS_CFG_W-1:0];
        rows_m = rows_word[srld_pkg::ROWS_CFG_W-1:0];
    endtask

    // Result side: random stalls per result, plus one long hold-off on request
    initial begin : result_stalls
        int wait_left;
        int drawn_for;
        out_stall = 1'b0;
        wait_left = 0;
        drawn_for = -1;
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            if (out_valid === 1'b1 && drawn_for != results_taken) begin
                drawn_for = results_taken;
                wait_left = quiet_rx ? 0 : $urandom_range(0, 4);
            end
            if (out_valid === 1'b1 && wait_left > 0) begin
                out_stall <= 1'b1;
                wait_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Compare every accepted result with the oldest one outstanding
    always @(posedge clk) begin : check_results
        srld_pkg::t_out_res want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
            results_taken++;
            if (awaited_results.size() == 0) begin
                mismatches++;
                $display("%0t: expected no result, got cell_value %h status %b",
                         $time, out_data.cell_value, out_data.status);
            end else begin
                want = awaited_results.pop_front();
                if (out_data.cell_value !== want.cell_value) begin
                    mismatches++;
                    $display("%0t: cell_value expected %h got %h",
                             $time, want.cell_value, out_data.cell_value);
                end
                if (out_data.status !== want.status) begin
                    mismatches++;
                    $display("%0t: status expected %b got %b",
                             $time, want.status, out_data.status);
                end
            end
        end
    end

    // Stop the run if neither channel moves for too long
    always @(posedge clk) begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0)) begin
            idle_cycles <= 0;
        end else begin
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        srld_pkg::t_in_req req;
        int                rows_now;
        int                cols_now;
        int                roll;
        int                top;
        int                bottom;
        int                count;
        int                height;
        int                rrow;
        int                rcol;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_we        = 1'b0;
        cfg_idx       = srld_pkg::CFG_COLUMNS;
        cfg_data      = '0;
        mismatches    = 0;
        results_taken = 0;
        idle_cycles   = 0;
        quiet_tx      = 1'b0;
        quiet_rx      = 1'b0;
        hold_off_req  = 1'b0;

        // Shadow state after reset
        for (int r = 0; r < ROW_LIMIT; r++)
            row_map_m[r] = r[srld_pkg::TOP_W-1:0];
        for (int i = 0; i < ROW_LIMIT*COL_LIMIT; i++)
            screen_m[i] = '0;
        cols_m = srld_pkg::COLS_RESET;
        rows_m = srld_pkg::ROWS_RESET;

        // Directed requests at the reset geometry of 80 columns by 24 rows
        script.push_back('{cmd(srld_pkg::MODE_READ, 0, 0, 0, 32'h0, 0, 0), KEYED, ZERO_DONE});
        script.push_back('{cmd(srld_pkg::MODE_READ, 0, 0, 0, 32'h0, 23, 79), KEYED,
                           ZERO_DONE});
        script.push_back('{cmd(srld_pkg::MODE_READ, 0, 0, 0, 32'h0, 24, 0), KEYED, REJECTED});
        script.push_back('{cmd(srld_pkg::MODE_READ, 0, 0, 0, 32'h0, 0, 80), KEYED, REJECTED});
        script.push_back('{cmd(srld_pkg::MODE_READ, 0, 0, 0, 32'h0, 63, 255), KEYED,
                           REJECTED});
        script.push_back('{cmd(MODE_SPARE, 127, 63, 127, 32'hFFFF_FFFF, 63, 255), KEYED,
                           REJECTED});
        script.push_back('{cmd(srld_pkg::MODE_INSERT, 0, 0, 24, 32'hDEAD_BEEF, 0, 0), KEYED,
                           ZERO_DONE});
        script.push_back('{cmd(srld_pkg::MODE_INSERT, 1, 0, 24, 32'hFFFF_FFFF, 0, 0), KEYED,
                           ZERO_DONE});
        script.push_back('{cmd(srld_pkg::MODE_READ, 0, 0, 0, 32'h0, 0, 0), PREDICTED,
                           ZERO_DONE});
        script.push_back('{cmd(srld_pkg::MODE_READ, 0, 0, 0, 32'h0, 0, 79), PREDICTED,
                           ZERO_DONE});
        script.push_back('{cmd(srld_pkg::MODE_READ, 0, 0, 0, 32'h0, 1, 0), PREDICTED,
                           ZERO_DONE});
        script.push_back('{cmd(srld_pkg::MODE_DELETE, 2, 5, 10, 32'hA5A5_A5A5, 0, 0), KEYED,
                           ZERO_DONE});
        script.push_back('{cmd(srld_pkg::MODE_READ, 0, 0, 0, 32'h0, 9, 3), PREDICTED,
                           ZERO_DONE});
        script.push_back('{cmd(srld_pkg::MODE_READ, 0, 0, 0, 32'h0, 8, 3), PREDICTED,
                           ZERO_DONE});
        script.push_back('{cmd(srld_pkg::MODE_READ, 0, 0, 0, 32'h0, 5, 3), PREDICTED,
                           ZERO_DONE});
        // line count well past the region height
        script.push_back('{cmd(srld_pkg::MODE_INSERT, 127, 20, 24, 32'h1234_5678, 0, 0),
                           KEYED, ZERO_DONE});
        script.push_back('{cmd(srld_pkg::MODE_READ, 0, 0, 0, 32'h0, 21, 40), PREDICTED,
                           ZERO_DONE});
        script.push_back('{cmd(srld_pkg::MODE_DELETE, 64, 0, 3, 32'h5A5A_5A5A, 0, 0), KEYED,
                           ZERO_DONE});
        script.push_back('{cmd(srld_pkg::MODE_READ, 0, 0, 0, 32'h0, 2, 0), PREDICTED,
                           ZERO_DONE});
        // bad regions: bottom past the rows in use, empty, top beyond bottom
        script.push_back('{cmd(srld_pkg::MODE_INSERT, 1, 0, 25, 32'h0, 0, 0), KEYED,
                           REJECTED});
        script.push_back('{cmd(srld_pkg::MODE_DELETE, 1, 10, 10, 32'h0, 0, 0), KEYED,
                           REJECTED});
        script.push_back('{cmd(srld_pkg::MODE_INSERT, 1, 63, 127, 32'h0, 0, 0), KEYED,
                           REJECTED});
        script.push_back('{cmd(srld_pkg::MODE_DELETE, 3, 12, 5, 32'h0, 0, 0), KEYED,
                           REJECTED});
        script.push_back('{cmd(srld_pkg::MODE_INSERT, 1, 23, 24, 32'h0000_0001, 0, 0), KEYED,
                           ZERO_DONE});
        script.push_back('{cmd(srld_pkg::MODE_READ, 0, 0, 0, 32'h0, 23, 0), PREDICTED,
                           ZERO_DONE});

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            issue_command(script[i].req, script[i].keyed, script[i].want);

        // Random phases, one screen geometry each
        for (int p = 0; p < PHASES; p++) begin
            set_geometry(geometry_plan[p].cols_word, geometry_plan[p].rows_word);
            for (int n = 0; n < int'(geometry_plan[p].items); n++) begin
                rows_now = usable_rows();
                cols_now = usable_cols();
                if ($urandom_range(0, 29) == 0)
                    quiet_tx = !quiet_tx;
                if ($urandom_range(0, 29) == 0)
                    quiet_rx = !quiet_rx;

                roll = $urandom_range(0, 99);
                if (roll < 35)
                    req.mode = srld_pkg::MODE_INSERT;
                else if (roll < 70)
                    req.mode = srld_pkg::MODE_DELETE;
                else if (roll < 95)
                    req.mode = srld_pkg::MODE_READ;
                else
                    req.mode = MODE_SPARE;

                // Mostly regions that fit, some raw ones
                if (rows_now > 0 && $urandom_range(0, 99) < 85) begin
                    bottom = $urandom_range(1, rows_now);
                    top    = $urandom_range(0, bottom - 1);
                end else begin
                    top    = $urandom_range(0, 63);
                    bottom = $urandom_range(0, 127);
                end
                height = (bottom > top) ? bottom - top : 1;

                // Keep wide rows cheap; elsewhere reach saturation often enough
                roll = $urandom_range(0, 99);
                if (cols_now > 32)
                    count = $urandom_range(0, 2);
                else if (roll < 60)
                    count = $urandom_range(0, 3);
                else if (roll < 80)
                    count = $urandom_range(0, height);
                else
                    count = $urandom_range(height, 127);

                if (rows_now > 0 && $urandom_range(0, 99) < 85)
                    rrow = $urandom_range(0, rows_now - 1);
                else
                    rrow = $urandom_range(0, 63);
                if (cols_now > 0 && $urandom_range(0, 99) < 85)
                    rcol = $urandom_range(0, cols_now - 1);
                else
                    rcol = $urandom_range(0, 255);

                req.line_count    = count[srld_pkg::COUNT_W-1:0];
                req.region_top    = top[srld_pkg::TOP_W-1:0];
                req.region_bottom = bottom[srld_pkg::BOTTOM_W-1:0];
                req.fill_cell     = $urandom;
                req.read_row      = rrow[srld_pkg::RROW_W-1:0];
                req.read_col      = rcol[srld_pkg::RCOL_W-1:0];

                // Back-pressure: long hold-off on results, then a full drain
                if (p == 0 && n == 20)
                    hold_off_req = 1'b1;
                if (p == 0 && n == 60)
                    drain_results();

                issue_command(req, PREDICTED, ZERO_DONE);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* scroll_region_line_insert_delete.f */
sv/srld_pkg.sv
sv/srld_rowmap.sv
sv/srld_cells.sv
sv/scroll_region_line_insert_delete.sv
dv/testbench.sv
